### hdl/owl_pkg.sv
`timescale 1ns / 1ps

package owl_pkg;

	// Byte framing
	localparam int BITS_PER_BYTE = 8;
	localparam int BIT_IDX_W     = $clog2(BITS_PER_BYTE);

	// Register widths and file layout
	localparam int LONG_W      = 16;
	localparam int SHORT_W     = 8;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = LONG_W;

	localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PRESENCE_WAIT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RESET_TAIL    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WRITE_ONE_LOW = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SLOT          = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_READ_LOW      = 3'd5;

	// Register reset values
	localparam logic [LONG_W-1:0]  RESET_LOW_DEF     = 16'd480;
	localparam logic [LONG_W-1:0]  PRESENCE_WAIT_DEF = 16'd80;
	localparam logic [LONG_W-1:0]  RESET_TAIL_DEF    = 16'd400;
	localparam logic [SHORT_W-1:0] WRITE_ONE_LOW_DEF = 8'd1;
	localparam logic [LONG_W-1:0]  SLOT_DEF          = 16'd60;
	localparam logic [SHORT_W-1:0] READ_LOW_DEF      = 8'd2;

	// Command codes
	localparam logic [1:0] REQ_RESET = 2'd0;
	localparam logic [1:0] REQ_WRITE = 2'd1;
	localparam logic [1:0] REQ_READ  = 2'd2;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_RST_LOW,
		PH_RST_WAIT,
		PH_RST_TAIL,
		PH_WR_LOW,
		PH_WR_HIGH,
		PH_RD_LOW,
		PH_RD_REC
	} owl_phase_t;

	typedef struct packed {
		logic [LONG_W-1:0]  reset_low_ticks;
		logic [LONG_W-1:0]  presence_wait_ticks;
		logic [LONG_W-1:0]  reset_tail_ticks;
		logic [SHORT_W-1:0] write_one_low_ticks;
		logic [LONG_W-1:0]  slot_ticks;
		logic [SHORT_W-1:0] read_low_ticks;
	} owl_cfg_t;

	typedef struct packed {
		logic                   cmd_valid;
		logic [1:0]             req_type;
		logic [SHORT_W-1:0]     write_data;
		logic                   bus_level;
	} owl_item_t;

	typedef struct packed {
		logic                   drive_low;
		logic                   busy_res;
		logic                   done_res;
		logic                   presence;
		logic [SHORT_W-1:0]     read_data;
	} owl_res_t;

endpackage

### hdl/owl_cmd_if.sv
`timescale 1ns / 1ps

interface owl_cmd_if;
	logic       valid;
	logic       ready;
	logic       cmd_valid;
	logic [1:0] req_type;
	logic [7:0] write_data;
	logic       bus_level;

	modport source (output valid, output cmd_valid, output req_type,
		output write_data, output bus_level, input ready);
	modport sink (input valid, input cmd_valid, input req_type,
		input write_data, input bus_level, output ready);
endinterface

### hdl/owl_res_if.sv
`timescale 1ns / 1ps

interface owl_res_if;
	logic       valid;
	logic       ready;
	logic       drive_low;
	logic       busy_res;
	logic       done_res;
	logic       presence;
	logic [7:0] read_data;

	modport source (output valid, output drive_low, output busy_res,
		output done_res, output presence, output read_data, input ready);
	modport sink (input valid, input drive_low, input busy_res,
		input done_res, input presence, input read_data, output ready);
endinterface

### hdl/one_wire_bus_master.sv
// A result is registered and is on the output in the cycle after its tick transfers in.
// Throughput: one tick per cycle unless res.ready holds the output; the output
// register lets a new tick enter in the same cycle the previous result is taken.
// The sequencer and counter update in a single pass of logic per tick.
// Reset (arst_n low): sequencer idle, presence and read byte cleared,
// timing registers return to their defaults, output empty.
`timescale 1ns / 1ps

module one_wire_bus_master (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [owl_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [owl_pkg::CFG_DATA_W-1:0]  cfg_data,
	owl_cmd_if.sink                         cmd,
	owl_res_if.source                       res
);

	owl_pkg::owl_cfg_t  cfg;
	owl_pkg::owl_item_t item;
	owl_pkg::owl_res_t  res_d;
	logic               in_ready;
	logic               step_en;

	assign cmd.ready = in_ready;
	assign step_en   = cmd.valid && in_ready;

	assign item.cmd_valid  = cmd.cmd_valid;
	assign item.req_type   = cmd.req_type;
	assign item.write_data = cmd.write_data;
	assign item.bus_level  = cmd.bus_level;

	owl_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	owl_fsm u_fsm (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (step_en),
		.cfg     (cfg),
		.item    (item),
		.res_d   (res_d)
	);

	owl_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (step_en),
		.res_d    (res_d),
		.in_ready (in_ready),
		.res      (res)
	);

endmodule

### hdl/owl_cfg.sv
`timescale 1ns / 1ps

module owl_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [owl_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [owl_pkg::CFG_DATA_W-1:0]  cfg_data,
	output owl_pkg::owl_cfg_t               cfg
);

	owl_pkg::owl_cfg_t cfg_q;

	// Timing register file; writes to unused indexes fall through
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reset_low_ticks     <= owl_pkg::RESET_LOW_DEF;
			cfg_q.presence_wait_ticks <= owl_pkg::PRESENCE_WAIT_DEF;
			cfg_q.reset_tail_ticks    <= owl_pkg::RESET_TAIL_DEF;
			cfg_q.write_one_low_ticks <= owl_pkg::WRITE_ONE_LOW_DEF;
			cfg_q.slot_ticks          <= owl_pkg::SLOT_DEF;
			cfg_q.read_low_ticks      <= owl_pkg::READ_LOW_DEF;
		end else if (cfg_we) begin
			unique case (cfg_index)
				owl_pkg::REG_RESET_LOW:     cfg_q.reset_low_ticks     <= cfg_data;
				owl_pkg::REG_PRESENCE_WAIT: cfg_q.presence_wait_ticks <= cfg_data;
				owl_pkg::REG_RESET_TAIL:    cfg_q.reset_tail_ticks    <= cfg_data;
				owl_pkg::REG_WRITE_ONE_LOW:
					cfg_q.write_one_low_ticks <= cfg_data[owl_pkg::SHORT_W-1:0];
				owl_pkg::REG_SLOT:          cfg_q.slot_ticks          <= cfg_data;
				owl_pkg::REG_READ_LOW:
					cfg_q.read_low_ticks <= cfg_data[owl_pkg::SHORT_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### hdl/owl_fsm.sv
`timescale 1ns / 1ps

module owl_fsm (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step_en,
	input  owl_pkg::owl_cfg_t    cfg,
	input  owl_pkg::owl_item_t   item,
	output owl_pkg::owl_res_t    res_d
);

	localparam int LW = owl_pkg::LONG_W;
	localparam int BW = owl_pkg::BIT_IDX_W;
	localparam int SW = owl_pkg::SHORT_W;
	localparam logic [BW-1:0] LAST_BIT = BW'(owl_pkg::BITS_PER_BYTE - 1);

	owl_pkg::owl_phase_t phase_q, phase_a, phase_n;
	logic [LW-1:0] tick_q, tick_n, tick_inc, len;
	logic [BW-1:0] bit_q, bit_n;
	logic [SW-1:0] shift_q, shift_a, shift_n;
	logic          pres_q, pres_n;
	logic [SW-1:0] rdata_q, rdata_n;
	logic          cur_bit, hit, take_cmd;

	// Command acceptance: only from idle, and only for a known request
	assign take_cmd = (phase_q == owl_pkg::PH_IDLE) && item.cmd_valid &&
		(item.req_type == owl_pkg::REQ_RESET || item.req_type == owl_pkg::REQ_WRITE ||
		 item.req_type == owl_pkg::REQ_READ);

	always_comb begin
		phase_a = phase_q;
		shift_a = shift_q;
		if (take_cmd) begin
			priority if (item.req_type == owl_pkg::REQ_RESET) begin
				phase_a = owl_pkg::PH_RST_LOW;
			end else if (item.req_type == owl_pkg::REQ_WRITE) begin
				phase_a = owl_pkg::PH_WR_LOW;
				shift_a = item.write_data;
			end else begin
				phase_a = owl_pkg::PH_RD_LOW;
				shift_a = '0;
			end
		end
	end

	// Length of the current interval
	assign cur_bit = shift_a[take_cmd ? '0 : bit_q];

	always_comb begin
		unique case (phase_a)
			owl_pkg::PH_RST_LOW:  len = cfg.reset_low_ticks;
			owl_pkg::PH_RST_WAIT: len = cfg.presence_wait_ticks;
			owl_pkg::PH_RST_TAIL: len = cfg.reset_tail_ticks;
			owl_pkg::PH_WR_LOW:
				len = cur_bit ? LW'(cfg.write_one_low_ticks) : cfg.slot_ticks;
			owl_pkg::PH_WR_HIGH:  len = cur_bit ? cfg.slot_ticks : LW'(1);
			owl_pkg::PH_RD_LOW:   len = LW'(cfg.read_low_ticks);
			owl_pkg::PH_RD_REC:   len = cfg.slot_ticks;
			owl_pkg::PH_IDLE:     len = '0;
		endcase
	end

	// Shared tick counter; a zero length behaves as one tick
	assign tick_inc = (take_cmd ? LW'(0) : tick_q) + LW'(1);
	assign hit      = (tick_inc >= len) || (tick_inc == '0);

	// Next state
	always_comb begin
		phase_n = phase_a;
		tick_n  = take_cmd ? '0 : tick_q;
		bit_n   = take_cmd ? '0 : bit_q;
		shift_n = shift_a;
		pres_n  = pres_q;
		rdata_n = rdata_q;
		if (phase_a != owl_pkg::PH_IDLE) begin
			tick_n = hit ? '0 : tick_inc;
		end
		unique case (phase_a)
			owl_pkg::PH_RST_LOW: begin
				if (hit) phase_n = owl_pkg::PH_RST_WAIT;
			end
			owl_pkg::PH_RST_WAIT: begin
				if (hit) begin
					pres_n  = ~item.bus_level;
					phase_n = (cfg.reset_tail_ticks == '0) ? owl_pkg::PH_IDLE
						: owl_pkg::PH_RST_TAIL;
				end
			end
			owl_pkg::PH_RST_TAIL: begin
				if (hit) phase_n = owl_pkg::PH_IDLE;
			end
			owl_pkg::PH_WR_LOW: begin
				if (hit) phase_n = owl_pkg::PH_WR_HIGH;
			end
			owl_pkg::PH_WR_HIGH: begin
				if (hit) begin
					if (bit_n == LAST_BIT) begin
						phase_n = owl_pkg::PH_IDLE;
					end else begin
						bit_n   = bit_n + BW'(1);
						phase_n = owl_pkg::PH_WR_LOW;
					end
				end
			end
			owl_pkg::PH_RD_LOW: begin
				if (hit) phase_n = owl_pkg::PH_RD_REC;
			end
			owl_pkg::PH_RD_REC: begin
				// sample on the first released tick of the slot
				if (!take_cmd && tick_q == '0) shift_n[bit_n] = shift_a[bit_n] | item.bus_level;
				if (hit) begin
					if (bit_n == LAST_BIT) begin
						rdata_n = shift_n;
						phase_n = owl_pkg::PH_IDLE;
					end else begin
						bit_n   = bit_n + BW'(1);
						phase_n = owl_pkg::PH_RD_LOW;
					end
				end
			end
			owl_pkg::PH_IDLE: ;
		endcase
	end

	// Result of this tick
	always_comb begin
		res_d.drive_low = (phase_a == owl_pkg::PH_RST_LOW) || (phase_a == owl_pkg::PH_WR_LOW)
			|| (phase_a == owl_pkg::PH_RD_LOW);
		res_d.busy_res  = (phase_a != owl_pkg::PH_IDLE);
		res_d.done_res  = (phase_a != owl_pkg::PH_IDLE) && (phase_n == owl_pkg::PH_IDLE);
		res_d.presence  = pres_n;
		res_d.read_data = rdata_n;
	end

	// State registers advance once per transferred tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= owl_pkg::PH_IDLE;
			tick_q  <= '0;
			bit_q   <= '0;
			shift_q <= '0;
			pres_q  <= 1'b0;
			rdata_q <= '0;
		end else if (step_en) begin
			phase_q <= phase_n;
			tick_q  <= tick_n;
			bit_q   <= bit_n;
			shift_q <= shift_n;
			pres_q  <= pres_n;
			rdata_q <= rdata_n;
		end
	end

	// Checks
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && res_d.done_res |-> res_d.busy_res)
		else $error("done without busy");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && res_d.done_res |=> phase_q == owl_pkg::PH_IDLE)
		else $error("command finished but sequencer not idle");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!step_en |=> $stable(phase_q) && $stable(tick_q) && $stable(bit_q))
		else $error("sequencer moved without a transfer");

endmodule

### hdl/owl_out.sv
`timescale 1ns / 1ps

module owl_out (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  owl_pkg::owl_res_t   res_d,
	output logic                in_ready,
	owl_res_if.source           res
);

	logic              valid_q;
	owl_pkg::owl_res_t data_q;

	// Free slot, or the held result leaves this cycle
	assign in_ready = !valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (res.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= res_d;
		end
	end

	assign res.valid     = valid_q;
	assign res.drive_low = data_q.drive_low;
	assign res.busy_res  = data_q.busy_res;
	assign res.done_res  = data_q.done_res;
	assign res.presence  = data_q.presence;
	assign res.read_data = data_q.read_data;

endmodule
